>>> hw/rtl/gn3_pkg.sv
// shared constants, types and the permutation table of the 3d gradient noise pipeline
package gn3_pkg;

	// fixed-point formats
	localparam int unsigned FRAC_BITS_DEF = 16;
	localparam int unsigned COORD_W       = 32;
	localparam int unsigned FRAC_W        = 16;
	localparam int unsigned FADE_W        = FRAC_W + 1;
	localparam int unsigned NOISE_W       = FRAC_W + 1;
	localparam int unsigned ONE_Q16       = 1 << FRAC_W;

	// hash codes that reuse the x offset as second term
	localparam logic [3:0] H_DUP_XA = 4'd12;
	localparam logic [3:0] H_DUP_XB = 4'd14;

	// stage enables of the fade pipeline
	typedef struct packed {
		logic en_s1;
		logic en_s2;
		logic en_s3;
	} fade_en_t;

	// lattice permutation table
	localparam logic [7:0] PERM_ROM [256] = '{
		8'd151, 8'd160, 8'd137, 8'd91,  8'd90,  8'd15,  8'd131, 8'd13,
		8'd201, 8'd95,  8'd96,  8'd53,  8'd194, 8'd233, 8'd7,   8'd225,
		8'd140, 8'd36,  8'd103, 8'd30,  8'd69,  8'd142, 8'd8,   8'd99,
		8'd37,  8'd240, 8'd21,  8'd10,  8'd23,  8'd190, 8'd6,   8'd148,
		8'd247, 8'd120, 8'd234, 8'd75,  8'd0,   8'd26,  8'd197, 8'd62,
		8'd94,  8'd252, 8'd219, 8'd203, 8'd117, 8'd35,  8'd11,  8'd32,
		8'd57,  8'd177, 8'd33,  8'd88,  8'd237, 8'd149, 8'd56,  8'd87,
		8'd174, 8'd20,  8'd125, 8'd136, 8'd171, 8'd168, 8'd68,  8'd175,
		8'd74,  8'd165, 8'd71,  8'd134, 8'd139, 8'd48,  8'd27,  8'd166,
		8'd77,  8'd146, 8'd158, 8'd231, 8'd83,  8'd111, 8'd229, 8'd122,
		8'd60,  8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92,  8'd41,
		8'd55,  8'd46,  8'd245, 8'd40,  8'd244, 8'd102, 8'd143, 8'd54,
		8'd65,  8'd25,  8'd63,  8'd161, 8'd1,   8'd216, 8'd80,  8'd73,
		8'd209, 8'd76,  8'd132, 8'd187, 8'd208, 8'd89,  8'd18,  8'd169,
		8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
		8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3,   8'd64,
		8'd52,  8'd217, 8'd226, 8'd250, 8'd124, 8'd123, 8'd5,   8'd202,
		8'd38,  8'd147, 8'd118, 8'd126, 8'd255, 8'd82,  8'd85,  8'd212,
		8'd207, 8'd206, 8'd59,  8'd227, 8'd47,  8'd16,  8'd58,  8'd17,
		8'd182, 8'd189, 8'd28,  8'd42,  8'd223, 8'd183, 8'd170, 8'd213,
		8'd119, 8'd248, 8'd152, 8'd2,   8'd44,  8'd154, 8'd163, 8'd70,
		8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43,  8'd172, 8'd9,
		8'd129, 8'd22,  8'd39,  8'd253, 8'd19,  8'd98,  8'd108, 8'd110,
		8'd79,  8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104,
		8'd218, 8'd246, 8'd97,  8'd228, 8'd251, 8'd34,  8'd242, 8'd193,
		8'd238, 8'd210, 8'd144, 8'd12,  8'd191, 8'd179, 8'd162, 8'd241,
		8'd81,  8'd51,  8'd145, 8'd235, 8'd249, 8'd14,  8'd239, 8'd107,
		8'd49,  8'd192, 8'd214, 8'd31,  8'd181, 8'd199, 8'd106, 8'd157,
		8'd184, 8'd84,  8'd204, 8'd176, 8'd115, 8'd121, 8'd50,  8'd45,
		8'd127, 8'd4,   8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
		8'd222, 8'd114, 8'd67,  8'd29,  8'd24,  8'd72,  8'd243, 8'd141,
		8'd128, 8'd195, 8'd78,  8'd66,  8'd215, 8'd61,  8'd156, 8'd180
	};

	function automatic logic [7:0] perm(input logic [7:0] idx);
		return PERM_ROM[idx];
	endfunction

endpackage

>>> hw/rtl/gn3_fade.sv
// three-stage quintic fade 6t^5 - 15t^4 + 10t^3 on a q0.16 fraction
module gn3_fade
	import gn3_pkg::*;
(
	input  logic                clk,
	input  fade_en_t            en,
	input  logic [FRAC_W-1:0]   t,
	output logic [FADE_W-1:0]   fade
);

	localparam int unsigned P_W   = FRAC_W + 4;
	localparam int unsigned PRD_W = FRAC_W + P_W;

	logic [FRAC_W-1:0]   t_s1, t2_s1, t3_s2;
	logic [P_W-1:0]      p_s2;
	logic [FADE_W-1:0]   fade_s3;
	logic [2*FRAC_W-1:0] sq, cube;
	logic [P_W:0]        p_full;
	logic [PRD_W-1:0]    prod;

	// square of the fraction
	assign sq = t * t;
	always_ff @(posedge clk) begin
		if (en.en_s1) begin
			t_s1  <= t;
			t2_s1 <= sq[2*FRAC_W-1:FRAC_W];
		end
	end

	// cube and the quadratic factor, the latter always positive
	assign cube   = t2_s1 * t_s1;
	assign p_full = (P_W+1)'(t2_s1) * (P_W+1)'(6) + (P_W+1)'(10 * ONE_Q16)
		- (P_W+1)'(t_s1) * (P_W+1)'(15);
	always_ff @(posedge clk) begin
		if (en.en_s2) begin
			t3_s2 <= cube[2*FRAC_W-1:FRAC_W];
			p_s2  <= p_full[P_W-1:0];
		end
	end

	// final product, at most 1.0
	assign prod = t3_s2 * p_s2;
	always_ff @(posedge clk) begin
		if (en.en_s3) begin
			fade_s3 <= prod[FRAC_W +: FADE_W];
		end
	end

	assign fade = fade_s3;

endmodule

>>> hw/rtl/gradient_noise_3d.sv
// 3d gradient noise: eight-stage pipeline, one point per cycle while out_ready is high
// throughput: one point per clock while out_ready is high
// longest path: one 18x20 multiply and add
// stall: each stage loads when it is empty or the next one moves, so bubbles close up
// reset: arst_n clears the stage valid bits only; the datapath registers are not reset
module gradient_noise_3d
	import gn3_pkg::*;
#(
	parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [COORD_W-1:0]  x_coord,
	input  logic signed [COORD_W-1:0]  y_coord,
	input  logic signed [COORD_W-1:0]  z_coord,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [NOISE_W-1:0]         noise_value
);

	localparam int unsigned NST   = 8;
	localparam int unsigned OFS_W = FRAC_W + 1;
	localparam int unsigned DOT_W = FRAC_W + 3;
	localparam int unsigned SUM_W = DOT_W + 1;

	// a + floor(s * (b - a) / 2^16)
	function automatic logic signed [DOT_W-1:0] lerp(
		input logic signed [DOT_W-1:0] a,
		input logic signed [DOT_W-1:0] b,
		input logic [FADE_W-1:0]       s
	);
		logic signed [DOT_W:0]              diff;
		logic signed [FADE_W+DOT_W+1:0]     prod;
		logic signed [FADE_W+DOT_W+1-FRAC_W:0] sum;
		diff = {b[DOT_W-1], b} - {a[DOT_W-1], a};
		prod = $signed({1'b0, s}) * diff;
		sum  = prod[FADE_W+DOT_W+1:FRAC_W]
			+ {{(FADE_W+2-FRAC_W){a[DOT_W-1]}}, a};
		return sum[DOT_W-1:0];
	endfunction

	// gradient dot product chosen by the low hash nibble
	function automatic logic signed [DOT_W-1:0] grad_dot(
		input logic [3:0]              h,
		input logic signed [OFS_W-1:0] dx,
		input logic signed [OFS_W-1:0] dy,
		input logic signed [OFS_W-1:0] dz
	);
		logic signed [DOT_W-1:0] u, v;
		u = h[3] ? DOT_W'(dy) : DOT_W'(dx);
		if (h[3:2] == 2'b00) begin
			v = DOT_W'(dy);
		end else if (h == H_DUP_XA || h == H_DUP_XB) begin
			v = DOT_W'(dx);
		end else begin
			v = DOT_W'(dz);
		end
		return (h[0] ? -u : u) + (h[1] ? -v : v);
	endfunction

	// stage handshake
	logic [NST:1]   vld_q;
	logic [NST+1:1] en;

	always_comb begin
		en[NST+1] = out_ready;
		for (int k = NST; k >= 1; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1]) begin
				vld_q[1] <= in_valid;
			end
			for (int k = 2; k <= NST; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign in_ready  = en[1];
	assign out_valid = vld_q[NST];

	// lattice split: eight index bits above the fraction, fraction aligned to q0.16
	logic [7:0]        xi, yi, zi;
	logic [FRAC_W-1:0] fx, fy, fz;

	assign xi = 8'(x_coord >> FRAC_BITS);
	assign yi = 8'(y_coord >> FRAC_BITS);
	assign zi = 8'(z_coord >> FRAC_BITS);
	assign fx = FRAC_W'({x_coord, {FRAC_W{1'b0}}} >> FRAC_BITS);
	assign fy = FRAC_W'({y_coord, {FRAC_W{1'b0}}} >> FRAC_BITS);
	assign fz = FRAC_W'({z_coord, {FRAC_W{1'b0}}} >> FRAC_BITS);

	// fade units, aligned with stages one to three
	fade_en_t          fade_en;
	logic [FADE_W-1:0] su_s3, sv_s3, sw_s3;

	assign fade_en = '{en_s1: en[1], en_s2: en[2], en_s3: en[3]};

	gn3_fade u_fade_x (.clk(clk), .en(fade_en), .t(fx), .fade(su_s3));
	gn3_fade u_fade_y (.clk(clk), .en(fade_en), .t(fy), .fade(sv_s3));
	gn3_fade u_fade_z (.clk(clk), .en(fade_en), .t(fz), .fade(sw_s3));

	// stage 1: first hash level
	logic [7:0]        ha_s1, hb_s1, zi_s1;
	logic [FRAC_W-1:0] fx_s1, fy_s1, fz_s1;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			ha_s1 <= perm(xi) + yi;
			hb_s1 <= perm(8'(xi + 8'd1)) + yi;
			zi_s1 <= zi;
			fx_s1 <= fx;
			fy_s1 <= fy;
			fz_s1 <= fz;
		end
	end

	// stage 2: second hash level, one sum per x/y corner pair
	logic [7:0]        hsum_s2 [4];
	logic [FRAC_W-1:0] fx_s2, fy_s2, fz_s2;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			hsum_s2[0] <= perm(ha_s1) + zi_s1;
			hsum_s2[1] <= perm(hb_s1) + zi_s1;
			hsum_s2[2] <= perm(8'(ha_s1 + 8'd1)) + zi_s1;
			hsum_s2[3] <= perm(8'(hb_s1 + 8'd1)) + zi_s1;
			fx_s2      <= fx_s1;
			fy_s2      <= fy_s1;
			fz_s2      <= fz_s1;
		end
	end

	// stage 3: corner hashes, corner bit 0 is x, bit 1 is y, bit 2 is z
	logic [3:0]        hash [8];
	logic [3:0]        hash_s3 [8];
	logic [FRAC_W-1:0] fx_s3, fy_s3, fz_s3;
	logic [7:0]        hrom;

	always_comb begin
		hrom = '0;
		for (int c = 0; c < 8; c++) begin
			hrom    = perm(8'(hsum_s2[2'(c)] + 8'(c >> 2)));
			hash[c] = hrom[3:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			hash_s3 <= hash;
			fx_s3   <= fx_s2;
			fy_s3   <= fy_s2;
			fz_s3   <= fz_s2;
		end
	end

	// stage 4: corner dot products, far corner offsets are fraction minus one
	logic signed [DOT_W-1:0] dot [8];
	logic signed [DOT_W-1:0] dot_s4 [8];
	logic [FADE_W-1:0]       su_s4, sv_s4, sw_s4;

	always_comb begin
		for (int c = 0; c < 8; c++) begin
			dot[c] = grad_dot(hash_s3[c],
				$signed({1'((c >> 0) & 1), fx_s3}),
				$signed({1'((c >> 1) & 1), fy_s3}),
				$signed({1'((c >> 2) & 1), fz_s3}));
		end
	end

	always_ff @(posedge clk) begin
		if (en[4]) begin
			dot_s4 <= dot;
			su_s4  <= su_s3;
			sv_s4  <= sv_s3;
			sw_s4  <= sw_s3;
		end
	end

	// stage 5: blend along x
	logic signed [DOT_W-1:0] ex_s5 [4];
	logic [FADE_W-1:0]       sv_s5, sw_s5;

	always_ff @(posedge clk) begin
		if (en[5]) begin
			for (int j = 0; j < 4; j++) begin
				ex_s5[j] <= lerp(dot_s4[2*j], dot_s4[2*j+1], su_s4);
			end
			sv_s5 <= sv_s4;
			sw_s5 <= sw_s4;
		end
	end

	// stage 6: blend along y
	logic signed [DOT_W-1:0] ey_s6 [2];
	logic [FADE_W-1:0]       sw_s6;

	always_ff @(posedge clk) begin
		if (en[6]) begin
			ey_s6[0] <= lerp(ex_s5[0], ex_s5[1], sv_s5);
			ey_s6[1] <= lerp(ex_s5[2], ex_s5[3], sv_s5);
			sw_s6    <= sw_s5;
		end
	end

	// stage 7: blend along z
	logic signed [DOT_W-1:0] n_s7;

	always_ff @(posedge clk) begin
		if (en[7]) begin
			n_s7 <= lerp(ey_s6[0], ey_s6[1], sw_s6);
		end
	end

	// stage 8: shift to 0..2, saturate, halve
	logic signed [SUM_W-1:0] shifted;
	logic [SUM_W-1:0]        clamped;
	logic [NOISE_W-1:0]      noise_s8;

	always_comb begin
		shifted = {n_s7[DOT_W-1], n_s7} + SUM_W'(ONE_Q16);
		if (shifted[SUM_W-1]) begin
			clamped = '0;
		end else if (shifted > $signed(SUM_W'(2 * ONE_Q16))) begin
			clamped = SUM_W'(2 * ONE_Q16);
		end else begin
			clamped = shifted;
		end
	end

	always_ff @(posedge clk) begin
		if (en[8]) begin
			noise_s8 <= clamped[NOISE_W:1];
		end
	end

	assign noise_value = noise_s8;

endmodule
